[rtl/tdrf_pkg.sv]
// Package for the tile dirty-rectangle finder.
// Holds the transaction payload types, register codes, widths and clamping helpers.
// It depends on nothing; every other file in rtl imports it.
package tdrf_pkg;

   localparam int COORD_W     = 12;
   localparam int FRAME_REG_W = 13;
   localparam int TILE_REG_W  = 9;
   localparam int TILE_POS_W  = 8;
   localparam int WORD_W      = 32;
   localparam int WORD_BITS   = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 13;

   localparam logic [WORD_W-1:0] WORD_MASK = WORD_W'((64'd1 << WORD_BITS) - 64'd1);

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_WIDTH   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_HEIGHT  = 4'd3;

   localparam logic [FRAME_REG_W-1:0] FRAME_LIMIT        = 13'd4096;
   localparam logic [TILE_REG_W-1:0]  TILE_LIMIT         = 9'd256;
   localparam logic [FRAME_REG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [FRAME_REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [TILE_REG_W-1:0]  TILE_WIDTH_RESET   = 9'd32;
   localparam logic [TILE_REG_W-1:0]  TILE_HEIGHT_RESET  = 9'd32;

   typedef struct packed {
      logic [WORD_W-1:0] previous_word;
      logic [WORD_W-1:0] current_word;
      logic              frame_start;
   } req_payload_type;

   typedef struct packed {
      logic               tile_changed;
      logic [COORD_W-1:0] rect_left;
      logic [COORD_W-1:0] rect_top;
      logic [COORD_W-1:0] rect_right;
      logic [COORD_W-1:0] rect_bottom;
      logic               frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic               changed;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } tile_box_type;

   typedef struct packed {
      logic busy;
      logic done;
   } loc_status_type;

   function automatic logic [FRAME_REG_W-1:0] clamp_frame(input logic [FRAME_REG_W-1:0] v);
      if (v == '0) return FRAME_REG_W'(1);
      if (v > FRAME_LIMIT) return FRAME_LIMIT;
      return v;
   endfunction

   function automatic logic [TILE_REG_W-1:0] clamp_tile(input logic [TILE_REG_W-1:0] v);
      if (v == '0) return TILE_REG_W'(1);
      if (v > TILE_LIMIT) return TILE_LIMIT;
      return v;
   endfunction

endpackage

[rtl/tdrf_locate.sv]
// Serial locator: turns a column and row into the position inside the tile and the tile column.
// Restoring division, one quotient bit per cycle for column and row together.
// Depends on tdrf_pkg.
module tdrf_locate
   import tdrf_pkg::*;
#(
   parameter int MAX_TILE_COLUMNS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [COORD_W-1:0]       col,
   input  logic [COORD_W-1:0]       row,
   input  logic [TILE_REG_W-1:0]    tile_w,
   input  logic [TILE_REG_W-1:0]    tile_h,
   output loc_status_type           status,
   output logic [TILE_POS_W-1:0]    tile_lx,
   output logic [TILE_POS_W-1:0]    tile_ly,
   output logic [((MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1)-1:0] tile_col
);

   localparam int SLOT_W = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
   localparam int STEP_W = $clog2(COORD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COORD_W - 1);
   localparam logic [SLOT_W:0]   SLOT_MOD  = (SLOT_W + 1)'(MAX_TILE_COLUMNS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COORD_W-1:0]    xs_ff, xs_in;
   logic [COORD_W-1:0]    ys_ff, ys_in;
   logic [TILE_POS_W-1:0] rx_ff, rx_in;
   logic [TILE_POS_W-1:0] ry_ff, ry_in;
   logic [SLOT_W-1:0]     q_ff, q_in;
   logic [TILE_REG_W-1:0] tw_ff, tw_in;
   logic [TILE_REG_W-1:0] th_ff, th_in;

   logic [TILE_REG_W-1:0] trial_x, trial_y;
   logic                  ge_x, ge_y;
   logic [SLOT_W:0]       q_trial;

   always_comb begin
      trial_x = {rx_ff, xs_ff[COORD_W-1]};
      trial_y = {ry_ff, ys_ff[COORD_W-1]};
      ge_x    = trial_x >= tw_ff;
      ge_y    = trial_y >= th_ff;
      q_trial = {q_ff, ge_x};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      xs_in   = xs_ff;
      ys_in   = ys_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      q_in    = q_ff;
      tw_in   = tw_ff;
      th_in   = th_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         xs_in   = col;
         ys_in   = row;
         rx_in   = '0;
         ry_in   = '0;
         q_in    = '0;
         tw_in   = tile_w;
         th_in   = tile_h;
      end else if (busy_ff) begin
         xs_in = {xs_ff[COORD_W-2:0], 1'b0};
         ys_in = {ys_ff[COORD_W-2:0], 1'b0};
         rx_in = ge_x ? TILE_POS_W'(trial_x - tw_ff) : trial_x[TILE_POS_W-1:0];
         ry_in = ge_y ? TILE_POS_W'(trial_y - th_ff) : trial_y[TILE_POS_W-1:0];
         // The quotient is kept modulo the number of store entries as it is built.
         q_in  = (q_trial >= SLOT_MOD) ? SLOT_W'(q_trial - SLOT_MOD) : q_trial[SLOT_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      xs_ff <= xs_in;
      ys_ff <= ys_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      q_ff  <= q_in;
      tw_ff <= tw_in;
      th_ff <= th_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign tile_lx     = rx_ff;
   assign tile_ly     = ry_ff;
   assign tile_col    = q_ff;

endmodule

[rtl/tile_dirty_rectangle_finder_core.sv]
// Top level of the tile dirty-rectangle finder.
// Holds the raster position, the per-tile-column box memory and the result queue.
// Depends on tdrf_pkg and tdrf_locate.

// The block takes one word pair per transaction in raster order and, at the last word of
// each tile, returns one result transaction with the tile's changed flag and the absolute
// bounding box of the differing words. It sustains one input transaction per clock cycle while
// req_stall is low; the word that finishes a tile is registered in the read stage, and its result
// then in the result queue. The tile boxes live in a synchronous memory with one entry per
// tile column, read when a word is taken and written back the following cycle, with the last
// write forwarded to the next word. A three-entry result queue lets the input keep flowing
// while a result waits on rsp_stall. After every configuration write the input is stalled
// while a serial divider, one quotient bit per cycle over the 12-bit coordinates, works out
// where the current position falls inside its tile under the new sizes.
module tile_dirty_rectangle_finder_core
   import tdrf_pkg::*;
#(
   parameter int MAX_TILE_COLUMNS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SLOT_W = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TILE_COLUMNS - 1);
   localparam int RSP_DEPTH = 3;
   localparam int PTR_W     = 2;
   localparam int CNT_W     = 2;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RSP_DEPTH - 1);

   // Configuration, held already clamped to the legal ranges.
   logic [FRAME_REG_W-1:0] fw_ff, fw_in;
   logic [FRAME_REG_W-1:0] fh_ff, fh_in;
   logic [TILE_REG_W-1:0]  tw_ff, tw_in;
   logic [TILE_REG_W-1:0]  th_ff, th_in;
   logic                   recalc_ff;

   // Raster position of the next word and where it sits inside its tile.
   logic [COORD_W-1:0]    col_ff, col_in;
   logic [COORD_W-1:0]    row_ff, row_in;
   logic [TILE_POS_W-1:0] lx_ff, lx_in;
   logic [TILE_POS_W-1:0] ly_ff, ly_in;
   logic [SLOT_W-1:0]     tc_ff, tc_in;

   loc_status_type        loc_status;
   logic [TILE_POS_W-1:0] loc_lx, loc_ly;
   logic [SLOT_W-1:0]     loc_col;

   // Word position after the frame-start and out-of-frame corrections.
   logic [COORD_W-1:0]     x0;
   logic [FRAME_REG_W-1:0] y0;
   logic [TILE_POS_W-1:0]  lx0, ly0;
   logic [SLOT_W-1:0]      tc0;
   logic                   col_last, row_last, lx_last, ly_last;
   logic                   accept, word_diff;

   // Read stage.
   logic               s1_valid_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic [SLOT_W-1:0]  s1_slot_ff;
   logic               s1_first_ff, s1_diff_ff, s1_last_ff, s1_frame_ff;
   tile_box_type       rd_data_ff;

   // Last write back, kept for forwarding.
   logic               wb_valid_ff;
   logic [SLOT_W-1:0]  wb_slot_ff;
   tile_box_type       wb_data_ff;

   tile_box_type       box_mem [MAX_TILE_COLUMNS];
   tile_box_type       box_base, box_new;

   // Result queue.
   rsp_payload_type    fifo_ff [RSP_DEPTH];
   rsp_payload_type    push_data;
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   // ------------------------------------------------------------------
   // Configuration port. Every write, whatever its index, restarts the locator,
   // so the position inside the tile always matches the registers in force.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      tw_in = tw_ff;
      th_in = th_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_in = clamp_frame(csr_wdata);
            CSR_FRAME_HEIGHT: fh_in = clamp_frame(csr_wdata);
            CSR_TILE_WIDTH:   tw_in = clamp_tile(csr_wdata[TILE_REG_W-1:0]);
            CSR_TILE_HEIGHT:  th_in = clamp_tile(csr_wdata[TILE_REG_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff     <= FRAME_WIDTH_RESET;
         fh_ff     <= FRAME_HEIGHT_RESET;
         tw_ff     <= TILE_WIDTH_RESET;
         th_ff     <= TILE_HEIGHT_RESET;
         recalc_ff <= 1'b0;
      end else begin
         fw_ff     <= fw_in;
         fh_ff     <= fh_in;
         tw_ff     <= tw_in;
         th_ff     <= th_in;
         recalc_ff <= csr_valid && csr_ready;
      end
   end

   tdrf_locate #(
      .MAX_TILE_COLUMNS(MAX_TILE_COLUMNS)
   ) u_locate (
      .clock    (clock),
      .reset    (reset),
      .start    (recalc_ff),
      .col      (col_ff),
      .row      (row_ff),
      .tile_w   (tw_ff),
      .tile_h   (th_ff),
      .status   (loc_status),
      .tile_lx  (loc_lx),
      .tile_ly  (loc_ly),
      .tile_col (loc_col)
   );

   // ------------------------------------------------------------------
   // Input stage. The input is held off while the locator runs, and whenever the
   // queue plus the word in the read stage could fill the queue before a pop.
   // ------------------------------------------------------------------
   assign req_stall = recalc_ff || loc_status.busy || loc_status.done ||
                      (({1'b0, count_ff} + {{CNT_W{1'b0}}, s1_valid_ff}) > 3'd2);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      x0  = col_ff;
      y0  = {1'b0, row_ff};
      lx0 = lx_ff;
      ly0 = ly_ff;
      tc0 = tc_ff;
      if (req_payload.frame_start) begin
         x0  = '0;
         y0  = '0;
         lx0 = '0;
         ly0 = '0;
         tc0 = '0;
      end else if ({1'b0, col_ff} >= fw_ff) begin
         // Left over from a narrower frame: the word opens the next row.
         x0  = '0;
         lx0 = '0;
         tc0 = '0;
         y0  = {1'b0, row_ff} + FRAME_REG_W'(1);
         ly0 = ({1'b0, ly_ff} == th_ff - TILE_REG_W'(1)) ? '0 : ly_ff + TILE_POS_W'(1);
      end
      if (y0 >= fh_ff) begin
         x0  = '0;
         y0  = '0;
         lx0 = '0;
         ly0 = '0;
         tc0 = '0;
      end

      col_last  = {1'b0, x0} == fw_ff - FRAME_REG_W'(1);
      row_last  = y0 == fh_ff - FRAME_REG_W'(1);
      lx_last   = {1'b0, lx0} == tw_ff - TILE_REG_W'(1);
      ly_last   = {1'b0, ly0} == th_ff - TILE_REG_W'(1);
      word_diff = ((req_payload.previous_word ^ req_payload.current_word) & WORD_MASK) != '0;

      // Step the position on to the next word.
      col_in = col_ff;
      row_in = row_ff;
      lx_in  = lx_ff;
      ly_in  = ly_ff;
      tc_in  = tc_ff;
      if (loc_status.done) begin
         lx_in = loc_lx;
         ly_in = loc_ly;
         tc_in = loc_col;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            lx_in  = '0;
            tc_in  = '0;
            if (row_last) begin
               row_in = '0;
               ly_in  = '0;
            end else begin
               row_in = y0[COORD_W-1:0] + COORD_W'(1);
               ly_in  = ly_last ? '0 : ly0 + TILE_POS_W'(1);
            end
         end else begin
            col_in = x0 + COORD_W'(1);
            row_in = y0[COORD_W-1:0];
            ly_in  = ly0;
            lx_in  = lx_last ? '0 : lx0 + TILE_POS_W'(1);
            if (lx_last) begin
               tc_in = (tc0 == LAST_SLOT) ? '0 : tc0 + SLOT_W'(1);
            end else begin
               tc_in = tc0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         lx_ff       <= '0;
         ly_ff       <= '0;
         tc_ff       <= '0;
         s1_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         lx_ff       <= lx_in;
         ly_ff       <= ly_in;
         tc_ff       <= tc_in;
         s1_valid_ff <= accept;
         wb_valid_ff <= s1_valid_ff;
      end
      s1_x_ff     <= x0;
      s1_y_ff     <= y0[COORD_W-1:0];
      s1_slot_ff  <= tc0;
      s1_first_ff <= (lx0 == '0) && (ly0 == '0);
      s1_diff_ff  <= word_diff;
      s1_last_ff  <= (lx_last || col_last) && (ly_last || row_last);
      s1_frame_ff <= col_last && row_last;
      wb_slot_ff  <= s1_slot_ff;
      wb_data_ff  <= box_new;
   end

   // ------------------------------------------------------------------
   // Box memory: read at the entry of the incoming word, written back in the cycle
   // after. The write of the previous word lands on the same edge as the read of
   // the present one, so that write is forwarded when the entries match.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      rd_data_ff <= box_mem[tc0];
      if (s1_valid_ff) begin
         box_mem[s1_slot_ff] <= box_new;
      end
   end

   always_comb begin
      if (wb_valid_ff && (wb_slot_ff == s1_slot_ff)) begin
         box_base = wb_data_ff;
      end else begin
         box_base = rd_data_ff;
      end
      if (s1_first_ff) begin
         box_base = '0;
      end

      box_new = box_base;
      if (s1_diff_ff) begin
         if (!box_base.changed) begin
            box_new.changed = 1'b1;
            box_new.left    = s1_x_ff;
            box_new.right   = s1_x_ff;
            box_new.top     = s1_y_ff;
            box_new.bottom  = s1_y_ff;
         end else begin
            if (s1_x_ff < box_base.left)   box_new.left   = s1_x_ff;
            if (s1_x_ff > box_base.right)  box_new.right  = s1_x_ff;
            if (s1_y_ff < box_base.top)    box_new.top    = s1_y_ff;
            if (s1_y_ff > box_base.bottom) box_new.bottom = s1_y_ff;
         end
      end

      push_data.tile_changed = box_new.changed;
      push_data.rect_left    = box_new.left;
      push_data.rect_top     = box_new.top;
      push_data.rect_right   = box_new.right;
      push_data.rect_bottom  = box_new.bottom;
      push_data.frame_done   = s1_frame_ff;
   end

   // ------------------------------------------------------------------
   // Result queue. The input stall rule guarantees it never overflows, so the
   // read stage always moves on.
   // ------------------------------------------------------------------
   assign push      = s1_valid_ff && s1_last_ff;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/tdrf_checker.sv]
// Port-level checks for the tile dirty-rectangle finder, and the bind that attaches them.
// Depends on tdrf_pkg and the ports of tile_dirty_rectangle_finder_core.
module tdrf_checker
   import tdrf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_payload_type        rsp_payload,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // A stalled result transaction stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result transaction changed while stalled");

   // A configuration write holds the input off while the tile position is recomputed.
   a_csr_stall: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("input taken straight after a configuration write");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A result only appears where an input transaction was taken earlier.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input transaction");

endmodule

bind tile_dirty_rectangle_finder_core tdrf_checker u_tdrf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);
